// ===== design/sed_pkg.sv =====
// package: shared constants, types and the per-channel sobel function
`timescale 1ns / 1ps
package sed_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int CHANNEL_BITS = 8;
    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int CFG_BITS = 11;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int PIX_BITS = 3 * CHANNEL_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef logic [PIX_BITS-1:0] pixel_t;

    // work passed from the front part to the back part
    typedef struct packed {
        pixel_t [8:0] win;      // index r*3+c
        logic         border;
        logic         last;
    } job_t;

    function automatic logic [CHANNEL_BITS-1:0] sobel_chan(
        input logic [CHANNEL_BITS-1:0] a, input logic [CHANNEL_BITS-1:0] b,
        input logic [CHANNEL_BITS-1:0] c, input logic [CHANNEL_BITS-1:0] d,
        input logic [CHANNEL_BITS-1:0] f, input logic [CHANNEL_BITS-1:0] g,
        input logic [CHANNEL_BITS-1:0] h, input logic [CHANNEL_BITS-1:0] i);
        logic signed [CHANNEL_BITS+3:0] gx;
        logic signed [CHANNEL_BITS+3:0] gy;
        logic [CHANNEL_BITS+2:0] ax;
        logic [CHANNEL_BITS+2:0] ay;
        logic [CHANNEL_BITS+3:0] s;
        gx = $signed({4'b0, a}) - $signed({4'b0, c}) + $signed({3'b0, d, 1'b0})
           - $signed({3'b0, f, 1'b0}) + $signed({4'b0, g}) - $signed({4'b0, i});
        gy = $signed({4'b0, a}) + $signed({3'b0, b, 1'b0}) + $signed({4'b0, c})
           - $signed({4'b0, g}) - $signed({3'b0, h, 1'b0}) - $signed({4'b0, i});
        ax = gx[CHANNEL_BITS+3] ? (CHANNEL_BITS+3)'(0) - gx[CHANNEL_BITS+2:0]
                                : gx[CHANNEL_BITS+2:0];
        ay = gy[CHANNEL_BITS+3] ? (CHANNEL_BITS+3)'(0) - gy[CHANNEL_BITS+2:0]
                                : gy[CHANNEL_BITS+2:0];
        s = {1'b0, ax} + {1'b0, ay};
        return (s > (CHANNEL_BITS+4)'((1 << CHANNEL_BITS) - 1))
            ? {CHANNEL_BITS{1'b1}} : s[CHANNEL_BITS-1:0];
    endfunction
endpackage

// ===== design/sed_front.sv =====
// front part: position tracking, line stores, window and border classing
`timescale 1ns / 1ps
module sed_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sed_pkg::CFG_BITS-1:0] cfg_width,
    input  logic [sed_pkg::CFG_BITS-1:0] cfg_height,
    input  logic                       push,
    output logic                       full,
    input  sed_pkg::pixel_t            pix,
    input  logic                       drain,
    output logic                       job_valid,
    output sed_pkg::job_t              job,
    input  logic                       q_full
);
    import sed_pkg::*;

    // line stores: read data registered, stage 1 holds the word alongside
    pixel_t upper_mem [MAX_WIDTH];
    pixel_t middle_mem [MAX_WIDTH];

    logic [CFG_BITS-1:0] w, h;
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [CFG_BITS-1:0] row_reg, row_next;
    logic                flushing, take, ic_last;

    // stage 1 registers
    logic                s1_valid_reg;
    pixel_t              s1_px_reg, s1_up_reg, s1_mid_reg;
    logic                s1_emit_reg;
    pixel_t              win_reg [9];
    logic [CFG_BITS-1:0] orow;
    logic [CFG_BITS-1:0] ocol;
    logic                fend;
    logic                stall;

    always_comb
    begin
        w = (cfg_width < CFG_BITS'(3)) ? CFG_BITS'(3)
          : (cfg_width > CFG_BITS'(MAX_WIDTH) ? CFG_BITS'(MAX_WIDTH) : cfg_width);
        h = (cfg_height < CFG_BITS'(3)) ? CFG_BITS'(3)
          : (cfg_height > CFG_BITS'(HEIGHT_LIMIT) ? CFG_BITS'(HEIGHT_LIMIT) : cfg_height);
    end

    // the queue keeps two spare slots, so one word in stage 1 always fits
    assign stall = q_full;
    assign full  = stall;
    assign flushing = (row_reg >= h);
    assign take = push && !full && !(drain && !flushing);
    assign ic_last = ({1'b0, col_reg} + CFG_BITS'(1)) >= w;
    // a column index past the width cannot happen once clamped
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (ic_last)
        begin
            col_next = '0;
            row_next = row_reg + CFG_BITS'(1);
        end
        else
        begin
            col_next = col_reg + COL_BITS'(1);
        end
        if (fend)
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    // output position and frame end of the current item, decided up front
    always_comb
    begin
        if (col_reg != '0)
        begin
            orow = row_reg - CFG_BITS'(1);
            ocol = {1'b0, col_reg} - CFG_BITS'(1);
        end
        else
        begin
            orow = row_reg - CFG_BITS'(2);
            ocol = w - CFG_BITS'(1);
        end
        fend = (row_reg >= CFG_BITS'(2) || (row_reg == CFG_BITS'(1) && col_reg != '0))
            && orow >= h - CFG_BITS'(1) && ocol == w - CFG_BITS'(1);
    end

    logic emit, border;
    assign emit = row_reg >= CFG_BITS'(2) || (row_reg == CFG_BITS'(1) && col_reg != '0);
    assign border = orow == '0 || orow >= h - CFG_BITS'(1) || ocol == '0
                 || ocol >= w - CFG_BITS'(1);
    logic s1_border_reg, s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_up_reg     <= upper_mem[col_reg];
            s1_mid_reg    <= middle_mem[col_reg];
            upper_mem[col_reg]  <= middle_mem[col_reg];
            middle_mem[col_reg] <= (flushing || drain) ? '0 : pix;
            s1_px_reg     <= (flushing || drain) ? '0 : pix;
            s1_emit_reg   <= emit;
            s1_border_reg <= border;
            s1_last_reg   <= fend;
        end
    end

    // window shift happens at stage 1; result uses the window after the shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= s1_up_reg;
            win_reg[5] <= s1_mid_reg;
            win_reg[8] <= s1_px_reg;
        end
    end

    // the window after the shift of this item
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            job.win[r*3]   = win_reg[r*3+1];
            job.win[r*3+1] = win_reg[r*3+2];
        end
        job.win[2] = s1_up_reg;
        job.win[5] = s1_mid_reg;
        job.win[8] = s1_px_reg;
        job.border = s1_border_reg;
        job.last   = s1_last_reg;
    end
    assign job_valid = s1_valid_reg && s1_emit_reg;
endmodule

// ===== design/sed_queue.sv =====
// short queue between the front and back parts
`timescale 1ns / 1ps
module sed_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  sed_pkg::job_t wdata,
    output logic          almost_full,
    output logic          not_empty,
    input  logic          rd,
    output sed_pkg::job_t rdata
);
    import sed_pkg::*;

    job_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wp_reg, rp_reg;
    logic [QPTR_BITS:0]   cnt_reg;

    // two slots are still free when full goes high
    assign almost_full = cnt_reg >= (QPTR_BITS+1)'(QUEUE_DEPTH - 2);
    assign not_empty = cnt_reg != '0;
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + QPTR_BITS'(1);
            if (rd)
                rp_reg <= rp_reg + QPTR_BITS'(1);
            cnt_reg <= cnt_reg + (QPTR_BITS+1)'(wr) - (QPTR_BITS+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end
endmodule

// ===== design/sed_back.sv =====
// back part: sobel per channel, or the centre pixel on the border, into the output register
`timescale 1ns / 1ps
module sed_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_ready,
    input  sed_pkg::job_t job,
    output logic          job_take,
    output logic          empty,
    input  logic          pop,
    output logic [sed_pkg::CHANNEL_BITS-1:0] edge_red,
    output logic [sed_pkg::CHANNEL_BITS-1:0] edge_green,
    output logic [sed_pkg::CHANNEL_BITS-1:0] edge_blue,
    output logic          frame_end
);
    import sed_pkg::*;

    logic   out_valid_reg;
    pixel_t res;
    pixel_t out_reg;
    logic   last_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (job.border)
                res[c*CHANNEL_BITS +: CHANNEL_BITS] = job.win[4][c*CHANNEL_BITS +: CHANNEL_BITS];
            else
                res[c*CHANNEL_BITS +: CHANNEL_BITS] = sobel_chan(
                    job.win[0][c*CHANNEL_BITS +: CHANNEL_BITS],
                    job.win[1][c*CHANNEL_BITS +: CHANNEL_BITS],
                    job.win[2][c*CHANNEL_BITS +: CHANNEL_BITS],
                    job.win[3][c*CHANNEL_BITS +: CHANNEL_BITS],
                    job.win[5][c*CHANNEL_BITS +: CHANNEL_BITS],
                    job.win[6][c*CHANNEL_BITS +: CHANNEL_BITS],
                    job.win[7][c*CHANNEL_BITS +: CHANNEL_BITS],
                    job.win[8][c*CHANNEL_BITS +: CHANNEL_BITS]);
        end
    end

    assign job_take = job_ready && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (job_take)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            out_reg  <= res;
            last_reg <= job.last;
        end
    end

    assign empty      = !out_valid_reg;
    assign edge_red   = out_reg[2*CHANNEL_BITS +: CHANNEL_BITS];
    assign edge_green = out_reg[CHANNEL_BITS +: CHANNEL_BITS];
    assign edge_blue  = out_reg[0 +: CHANNEL_BITS];
    assign frame_end  = last_reg;
endmodule

// ===== design/sobel_edge_rgb_3x3.sv =====
// top level: sobel 3x3 edge filter on an rgb pixel stream
//
// input queue side: a word (pixel_red/green/blue, drain) is taken when push
// is high and full is low. result queue side: the oldest result sits on
// edge_red/green/blue and frame_end while empty is low; pop takes it.
// each result belongs to the pixel frame_width+1 words earlier; after the
// last pixel of a frame send frame_width+1 drain words to flush the end.
// a drain word inside a frame is dropped. frame_end marks the last result.
// one word per cycle sustained while full stays low; a word taken passes the
// line store read register, the queue and the sobel output register in turn.
// cfg_we with cfg_index writes frame_width (0) or frame_height (1) and
// restarts the frame position; write only while idle.
// reset (rst_n low) restores 640 x 480, clears positions, queue and window.
// the line stores hold garbage until written; it only reaches border pixels.
// when the receiver stalls the internal queue fills and full rises.
`timescale 1ns / 1ps
module sobel_edge_rgb_3x3 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_index,
    input  logic [sed_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [sed_pkg::CHANNEL_BITS-1:0] pixel_red,
    input  logic [sed_pkg::CHANNEL_BITS-1:0] pixel_green,
    input  logic [sed_pkg::CHANNEL_BITS-1:0] pixel_blue,
    input  logic                             drain,
    output logic                             empty,
    input  logic                             pop,
    output logic [sed_pkg::CHANNEL_BITS-1:0] edge_red,
    output logic [sed_pkg::CHANNEL_BITS-1:0] edge_green,
    output logic [sed_pkg::CHANNEL_BITS-1:0] edge_blue,
    output logic                             frame_end
);
    import sed_pkg::*;

    logic [CFG_BITS-1:0] width_reg, height_reg;
    logic  job_valid, q_full, q_ne, q_rd;
    job_t  job_w, job_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_BITS'(640);
            height_reg <= CFG_BITS'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    sed_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
        .cfg_width(width_reg), .cfg_height(height_reg),
        .push(push), .full(full),
        .pix({pixel_red, pixel_green, pixel_blue}), .drain(drain),
        .job_valid(job_valid), .job(job_w), .q_full(q_full)
    );

    sed_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr(job_valid), .wdata(job_w),
        .almost_full(q_full), .not_empty(q_ne), .rd(q_rd), .rdata(job_q)
    );

    sed_back u_back (
        .clk(clk), .rst_n(rst_n), .job_ready(q_ne), .job(job_q),
        .job_take(q_rd), .empty(empty), .pop(pop),
        .edge_red(edge_red), .edge_green(edge_green), .edge_blue(edge_blue),
        .frame_end(frame_end)
    );
endmodule

// ===== design/sed_checker.sv =====
// port checker for the sobel block and its bind
`timescale 1ns / 1ps
module sed_checker (
    input logic clk,
    input logic rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic frame_end
);
    // a result shown stays until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty) else $error("result dropped");
    a_fend: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(frame_end)) else $error("frame_end changed");
    // out of reset nothing is queued, and no result shows while a first word is on its way
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty && !full ##1 empty ##1 empty)
        else $error("result too early after reset");
    a_rst: assert property (@(posedge clk)
        !rst_n |=> empty || !rst_n) else $error("reset not empty");
endmodule

bind sobel_edge_rgb_3x3 sed_checker u_sed_checker (
    .clk(clk), .rst_n(rst_n), .full(full),
    .empty(empty), .pop(pop), .frame_end(frame_end)
);

// ===== verif/tb_sobel_edge_rgb_3x3.sv =====
// testbench: random and directed rgb frames through the sobel filter, checked against a predictor
`timescale 1ns / 1ps
module tb_sobel_edge_rgb_3x3;
    import sed_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flush;
    } word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } edge_px_t;

    localparam int STALL_LIMIT = 4000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [0:0]              cfg_index = REG_WIDTH;
    logic [CFG_BITS-1:0]     cfg_data = '0;
    logic                    push = 1'b0;
    logic                    full;
    logic [CHANNEL_BITS-1:0] pixel_red = '0;
    logic [CHANNEL_BITS-1:0] pixel_green = '0;
    logic [CHANNEL_BITS-1:0] pixel_blue = '0;
    logic                    drain = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [CHANNEL_BITS-1:0] edge_red;
    logic [CHANNEL_BITS-1:0] edge_green;
    logic [CHANNEL_BITS-1:0] edge_blue;
    logic                    frame_end;

    sobel_edge_rgb_3x3 dut (.*);

    always #5 clk = ~clk;

    word_t    words_pending[$];
    edge_px_t edges_due[$];
    int       send_idle_pct = 0;
    int       take_idle_pct = 0;
    int       errors = 0;
    int       pixels_sent = 0;
    int       stall_cycles = 0;

    // predictor state
    logic [CFG_BITS-1:0] width_reg = 11'd640;
    logic [CFG_BITS-1:0] height_reg = 11'd480;
    pixel_t upper_line[MAX_WIDTH];
    pixel_t middle_line[MAX_WIDTH];
    pixel_t win[9];
    int     in_col = 0;
    int     in_row = 0;

    initial
    begin
        for (int k = 0; k < MAX_WIDTH; k++)
        begin
            upper_line[k] = '0;
            middle_line[k] = '0;
        end
        for (int k = 0; k < 9; k++)
            win[k] = '0;
    end

    function automatic logic [7:0] gradient(input int sh);
        int a, b, c, d, f, g, h, i, gx, gy, s;
        a = win[0][sh +: 8]; b = win[1][sh +: 8]; c = win[2][sh +: 8];
        d = win[3][sh +: 8]; f = win[5][sh +: 8];
        g = win[6][sh +: 8]; h = win[7][sh +: 8]; i = win[8][sh +: 8];
        gx = a - c + 2 * d - 2 * f + g - i;
        gy = a + 2 * b + c - g - 2 * h - i;
        s = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    function automatic void filter_word(input word_t wd);
        int w, hgt, ic, ir, orow, ocol;
        bit flushing;
        pixel_t px;
        edge_px_t e;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        hgt = (height_reg < 3) ? 3 : (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT
                                                                 : int'(height_reg);
        ir = in_row;
        ic = in_col;
        flushing = (ir >= hgt);
        // a drain inside the frame is dropped
        if (wd.flush && !flushing)
            return;
        px = (flushing || wd.flush) ? '0 : {wd.red, wd.green, wd.blue};
        if (ic >= w)
            ic = 0;
        for (int r = 0; r < 3; r++)
        begin
            win[r * 3] = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = upper_line[ic];
        win[5] = middle_line[ic];
        win[8] = px;
        upper_line[ic] = middle_line[ic];
        middle_line[ic] = px;
        if (ic + 1 >= w)
        begin
            in_col = 0;
            in_row = (ir + 1) & 'h7ff;
        end
        else
            in_col = ic + 1;
        if (!(ir >= 2 || (ir == 1 && ic >= 1)))
            return;
        if (ic >= 1)
        begin
            orow = ir - 1;
            ocol = ic - 1;
        end
        else
        begin
            orow = ir - 2;
            ocol = w - 1;
        end
        if (orow == 0 || orow >= hgt - 1 || ocol == 0 || ocol >= w - 1)
            {e.red, e.green, e.blue} = win[4];
        else
        begin
            e.red = gradient(16);
            e.green = gradient(8);
            e.blue = gradient(0);
        end
        e.last = (orow >= hgt - 1 && ocol == w - 1);
        if (e.last)
        begin
            in_row = 0;
            in_col = 0;
        end
        edges_due.push_back(e);
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            filter_word(words_pending.pop_front());
        end
        if (rst_n && words_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            push <= 1'b1;
            {pixel_red, pixel_green, pixel_blue, drain} <= words_pending[0];
        end
        else
            push <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (edges_due.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                edge_px_t e;
                e = edges_due.pop_front();
                if (edge_red !== e.red)
                begin
                    $error("edge_red expected %0d actual %0d", e.red, edge_red);
                    errors++;
                end
                if (edge_green !== e.green)
                begin
                    $error("edge_green expected %0d actual %0d", e.green, edge_green);
                    errors++;
                end
                if (edge_blue !== e.blue)
                begin
                    $error("edge_blue expected %0d actual %0d", e.blue, edge_blue);
                    errors++;
                end
                if (frame_end !== e.last)
                begin
                    $error("frame_end expected %0d actual %0d", e.last, frame_end);
                    errors++;
                end
            end
        end
        pop <= rst_n && ($urandom_range(99) >= take_idle_pct);
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_we || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("sobel_edge_rgb_3x3 regression: fail");
            $finish;
        end
    end

    task automatic wait_idle();
        do
            @(posedge clk);
        while (words_pending.size() != 0 || push || edges_due.size() != 0);
        // drains in flight give no result
        repeat (8) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data <= w[CFG_BITS-1:0];
        @(posedge clk);
        width_reg = w[CFG_BITS-1:0];
        in_col = 0;
        in_row = 0;
        cfg_index <= REG_HEIGHT;
        cfg_data <= h[CFG_BITS-1:0];
        @(posedge clk);
        height_reg = h[CFG_BITS-1:0];
        cfg_we <= 1'b0;
    endtask

    function automatic word_t pixel_word(input bit binary);
        word_t wd;
        wd.flush = 1'b0;
        if (binary)
        begin
            wd.red = $urandom_range(1) ? 8'hff : 8'h00;
            wd.green = $urandom_range(1) ? 8'hff : 8'h00;
            wd.blue = $urandom_range(1) ? 8'hff : 8'h00;
        end
        else
            {wd.red, wd.green, wd.blue} = 24'($urandom);
        return wd;
    endfunction

    // one frame plus its flush, with stray drains and pixels in the flush
    task automatic send_frame(input int w, input int h);
        int wc, hc;
        bit binary;
        word_t wd;
        wc = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        hc = (h < 3) ? 3 : (h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h;
        binary = ($urandom_range(3) == 0);
        for (int k = 0; k < wc * hc; k++)
        begin
            if ($urandom_range(19) == 0)
            begin
                wd = pixel_word(0);
                wd.flush = 1'b1;
                words_pending.push_back(wd);
            end
            words_pending.push_back(pixel_word(binary));
            pixels_sent++;
        end
        for (int k = 0; k <= wc; k++)
        begin
            wd = pixel_word(0);
            wd.flush = ($urandom_range(9) >= 3);
            words_pending.push_back(wd);
        end
        if ($urandom_range(9) == 0)
        begin
            wd = pixel_word(0);
            wd.flush = 1'b1;
            words_pending.push_back(wd);
        end
        // keep the queue short so idling reaches every part of the frame
        while (words_pending.size() > 64)
            @(posedge clk);
    endtask

    task automatic random_frames(input int goal);
        int w, h;
        while (pixels_sent < goal)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
            h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
            if ($urandom_range(2) == 0)
                set_frame(w, h);
            else
            begin
                set_frame(width_reg, height_reg);
                w = width_reg;
                h = height_reg;
            end
            send_frame(w, h);
        end
    endtask

    initial
    begin
        send_idle_pct = 32;
        take_idle_pct = 70;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 3x3 frame with channel extremes, stray drain, pixel in flush
        set_frame(3, 3);
        words_pending.push_back({8'h00, 8'h00, 8'h00, 1'b0});
        words_pending.push_back({8'hff, 8'hff, 8'hff, 1'b0});
        words_pending.push_back({8'h00, 8'hff, 8'h00, 1'b1});
        words_pending.push_back({8'h00, 8'hff, 8'h00, 1'b0});
        words_pending.push_back({8'hff, 8'h00, 8'hff, 1'b0});
        words_pending.push_back({8'h80, 8'h7f, 8'h01, 1'b0});
        words_pending.push_back({8'h00, 8'h00, 8'hff, 1'b0});
        words_pending.push_back({8'hff, 8'hff, 8'hff, 1'b0});
        words_pending.push_back({8'hff, 8'h00, 8'h00, 1'b0});
        words_pending.push_back({8'h55, 8'haa, 8'h55, 1'b0});
        words_pending.push_back({8'h00, 8'h00, 8'h00, 1'b1});
        words_pending.push_back({8'hab, 8'hcd, 8'hef, 1'b0});
        words_pending.push_back({8'h00, 8'h00, 8'h00, 1'b1});
        words_pending.push_back({8'h00, 8'h00, 8'h00, 1'b1});
        pixels_sent += 9;

        random_frames(440);
        send_idle_pct = 70;
        take_idle_pct = 32;
        random_frames(880);
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_frames(1300);

        // clamped register values
        set_frame(0, 0);
        send_frame(0, 0);
        set_frame(3, 3);
        send_frame(3, 3);

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("sobel_edge_rgb_3x3 regression: pass");
        else
            $display("sobel_edge_rgb_3x3 regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
design/sed_pkg.sv
design/sed_front.sv
design/sed_queue.sv
design/sed_back.sv
design/sobel_edge_rgb_3x3.sv
design/sed_checker.sv
verif/tb_sobel_edge_rgb_3x3.sv
